FILE: rtl/core/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define TESA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tesa assertion failed");

// clocked assertion that also holds across reset
`define TESA_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("tesa assertion failed");

`endif

FILE: rtl/core/tesa_pkg.sv
// shared types and codes of the two-ended stack allocator
`timescale 1ns / 1ps

package tesa_pkg;

   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_BEGIN = 2'd1;
   localparam logic [1:0] CMD_END   = 2'd2;
   localparam logic [1:0] CMD_FREE  = 2'd3;

   localparam logic [2:0] STATUS_OK           = 3'd0;
   localparam logic [2:0] STATUS_NO_MEM       = 3'd1;
   localparam logic [2:0] STATUS_MARK_OPEN    = 3'd2;
   localparam logic [2:0] STATUS_MARKS_FULL   = 3'd3;
   localparam logic [2:0] STATUS_END_MISMATCH = 3'd4;
   localparam logic [2:0] STATUS_FREE_NOT_TOP = 3'd5;
   localparam logic [2:0] STATUS_FREE_OPEN    = 3'd6;

   localparam logic [31:0] MEM_SIZE_RESET = 32'h1480_0000;

   typedef struct packed {
      logic [1:0]  cmd;
      logic        side;
      logic [31:0] size;
      logic [4:0]  align_log2;
      logic [7:0]  tag;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] address;
      logic [32:0] shortfall;
      logic [1:0]  freed_sides;
   } rsp_payload_type;

   typedef struct packed {
      logic sub;
      logic round;
   } alu_op_type;

endpackage

FILE: rtl/core/tesa_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps

interface tesa_req_if;
   import tesa_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface tesa_rsp_if;
   import tesa_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/tesa_alu.sv
// shared add / subtract unit with alignment masking and borrow out
`timescale 1ns / 1ps

module tesa_alu #(
   parameter int WIDTH = 34
) (
   input  tesa_pkg::alu_op_type op,
   input  logic [WIDTH-1:0]     a,
   input  logic [WIDTH-1:0]     b,
   input  logic [WIDTH-1:0]     mask,
   output logic [WIDTH-1:0]     result,
   output logic                 borrow
);
   import tesa_pkg::*;

   logic [WIDTH:0] total;

   assign total  = {1'b0, a} + {1'b0, (op.sub ? ~b : b)} + (WIDTH + 1)'(op.sub);
   assign borrow = op.sub & ~total[WIDTH];
   assign result = op.round ? (total[WIDTH-1:0] & ~mask) : total[WIDTH-1:0];

endmodule

FILE: rtl/core/tesa_mark_mem.sv
// mark store: one write port, one registered read port
`timescale 1ns / 1ps

module tesa_mark_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 40,
   parameter int AW    = 6
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/two_ended_stack_allocator.sv
// top level of the two-ended stack allocator
// One region is handed out from both ends: the low top grows up from 0, the
// high top grows down from the region size. Items arrive as beats on req_chan
// (cmd, side, size, align_log2, tag); each gives exactly one beat on rsp_chan
// (status, address, shortfall, freed_sides). csr_wen with csr_wdata sets the
// region size and re-initializes both tops and both mark stacks.
// The block takes one item at a time; req_chan.ready is high only when idle.
// States from the accepting edge to rsp_chan.valid:
//   allocate          ST_AL_1, ST_AL_2, ST_AL_3, ST_AL_DONE, ST_FINISH
//   begin / end mark  ST_MARK, ST_FINISH
//   free by tag       ST_SCAN over the marks of both sides, ST_SCAN_WAIT,
//                     ST_FREE_DONE, ST_FINISH; ST_FINISH waits while a response is held
// Allocation runs three passes through one shared add / subtract unit; a free
// scans every live mark through the single read port of the mark memory.
// The response sits in an output register; a new request is taken while it
// waits, and the next response waits for rsp_chan.ready.
// Reset clears both stacks, sets the low top to 0 and the high top to the
// reset region size; no clearing pass is needed.
`timescale 1ns / 1ps

module two_ended_stack_allocator #(
   parameter int MARK_DEPTH = 32,
   parameter int ADDR_WIDTH = 32,
   parameter int TAG_WIDTH  = 8
) (
   input  logic        clock,
   input  logic        reset,
   tesa_req_if.sink    req_chan,
   tesa_rsp_if.source  rsp_chan,
   input  logic        csr_wen,
   input  logic [31:0] csr_wdata
);
   import tesa_pkg::*;

   localparam int W       = (ADDR_WIDTH > 32 ? ADDR_WIDTH : 32) + 2;
   localparam int CW      = $clog2(MARK_DEPTH + 1);
   localparam int IW      = $clog2(2 * MARK_DEPTH);
   localparam int ENTRY_W = TAG_WIDTH + ADDR_WIDTH;

   localparam logic [CW-1:0] DEPTH_C = CW'(MARK_DEPTH);
   localparam logic [IW-1:0] HI_BASE = IW'(MARK_DEPTH);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_AL_1      = 4'd1;
   localparam logic [3:0] ST_AL_2      = 4'd2;
   localparam logic [3:0] ST_AL_3      = 4'd3;
   localparam logic [3:0] ST_AL_DONE   = 4'd4;
   localparam logic [3:0] ST_MARK      = 4'd5;
   localparam logic [3:0] ST_SCAN      = 4'd6;
   localparam logic [3:0] ST_SCAN_WAIT = 4'd7;
   localparam logic [3:0] ST_FREE_DONE = 4'd8;
   localparam logic [3:0] ST_FINISH    = 4'd9;

   // control state
   logic [3:0]            state_ff, state_in;
   logic [ADDR_WIDTH-1:0] low_top_ff, low_top_in;
   logic [ADDR_WIDTH-1:0] high_top_ff, high_top_in;
   logic [CW-1:0]         count0_ff, count0_in;
   logic [CW-1:0]         count1_ff, count1_in;
   logic [1:0]            open_ff, open_in;
   logic [TAG_WIDTH-1:0]  open_tag0_ff, open_tag0_in;
   logic [TAG_WIDTH-1:0]  open_tag1_ff, open_tag1_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rd_pend_ff, rd_pend_in;

   // item and working registers
   logic [1:0]            cmd_ff, cmd_in;
   logic                  side_ff, side_in;
   logic [31:0]           size_ff, size_in;
   logic [4:0]            al_ff, al_in;
   logic [TAG_WIDTH-1:0]  tag_ff, tag_in;
   logic [W-1:0]          acc_ff, acc_in;
   logic                  borrow_ff, borrow_in;
   logic [W-1:0]          hold_ff, hold_in;
   logic [W-1:0]          start_ff, start_in;
   logic                  over_ff, over_in;
   logic                  scan_side_ff, scan_side_in;
   logic [CW-1:0]         scan_idx_ff, scan_idx_in;
   logic                  rd_side_ff, rd_side_in;
   logic [CW-1:0]         rd_idx_ff, rd_idx_in;
   logic [1:0]            low_hit_ff, low_hit_in;
   logic [1:0]            top_hit_ff, top_hit_in;
   logic [ADDR_WIDTH-1:0] top_pos0_ff, top_pos0_in;
   logic [ADDR_WIDTH-1:0] top_pos1_ff, top_pos1_in;
   rsp_payload_type       res_ff, res_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   // datapath wires
   logic [TAG_WIDTH+7:0]  tag_ext;
   logic [ADDR_WIDTH+31:0] csr_ext;
   logic [ADDR_WIDTH+31:0] rst_ext;
   logic [31:0]           mask32;
   logic [W-1:0]          mask_w;
   logic [W-1:0]          low_w, high_w, size_w;
   alu_op_type            alu_op;
   logic [W-1:0]          alu_a, alu_b, alu_result;
   logic                  alu_borrow;
   logic                  mem_we;
   logic [IW-1:0]         mem_waddr, mem_raddr;
   logic [ENTRY_W-1:0]    mem_wdata, mem_rdata;
   logic [TAG_WIDTH-1:0]  rd_tag;
   logic [ADDR_WIDTH-1:0] rd_pos;
   logic [CW-1:0]         side_cnt, scan_cnt, rd_cnt;
   logic                  rd_hit, rd_last;
   logic                  al_fail;
   logic [32:0]           sat_short;
   logic [1:0]            err_top, err_open, free_ok;

   assign tag_ext = {{TAG_WIDTH{1'b0}}, req_chan.data.tag};
   assign csr_ext = {{ADDR_WIDTH{1'b0}}, csr_wdata};
   assign rst_ext = {{ADDR_WIDTH{1'b0}}, MEM_SIZE_RESET};

   assign mask32 = (32'd1 << al_ff) - 32'd1;
   assign mask_w = W'(mask32);
   assign low_w  = W'(low_top_ff);
   assign high_w = W'(high_top_ff);
   assign size_w = W'(size_ff);

   assign side_cnt = side_ff ? count1_ff : count0_ff;
   assign scan_cnt = scan_side_ff ? count1_ff : count0_ff;
   assign rd_cnt   = rd_side_ff ? count1_ff : count0_ff;

   assign mem_waddr = side_ff ? (HI_BASE + IW'(side_cnt)) : IW'(side_cnt);
   assign mem_raddr = scan_side_ff ? (HI_BASE + IW'(scan_idx_ff)) : IW'(scan_idx_ff);
   assign mem_wdata = {tag_ff, (side_ff ? high_top_ff : low_top_ff)};

   assign rd_tag  = mem_rdata[ENTRY_W-1:ADDR_WIDTH];
   assign rd_pos  = mem_rdata[ADDR_WIDTH-1:0];
   assign rd_hit  = (rd_tag == tag_ff);
   assign rd_last = (rd_idx_ff == (rd_cnt - CW'(1)));

   assign al_fail   = ~borrow_ff & (|acc_ff);
   assign sat_short = (|acc_ff[W-1:33]) ? {33{1'b1}} : acc_ff[32:0];

   assign err_top  = low_hit_ff;
   assign err_open = ~low_hit_ff & top_hit_ff & open_ff;
   assign free_ok  = ~low_hit_ff & top_hit_ff & ~open_ff;

   tesa_alu #(
      .WIDTH (W)
   ) u_alu (
      .op     (alu_op),
      .a      (alu_a),
      .b      (alu_b),
      .mask   (mask_w),
      .result (alu_result),
      .borrow (alu_borrow)
   );

   tesa_mark_mem #(
      .DEPTH (2 * MARK_DEPTH),
      .WIDTH (ENTRY_W),
      .AW    (IW)
   ) u_mark_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      low_top_in   = low_top_ff;
      high_top_in  = high_top_ff;
      count0_in    = count0_ff;
      count1_in    = count1_ff;
      open_in      = open_ff;
      open_tag0_in = open_tag0_ff;
      open_tag1_in = open_tag1_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      rd_pend_in   = 1'b0;
      cmd_in       = cmd_ff;
      side_in      = side_ff;
      size_in      = size_ff;
      al_in        = al_ff;
      tag_in       = tag_ff;
      acc_in       = acc_ff;
      borrow_in    = borrow_ff;
      hold_in      = hold_ff;
      start_in     = start_ff;
      over_in      = over_ff;
      scan_side_in = scan_side_ff;
      scan_idx_in  = scan_idx_ff;
      rd_side_in   = rd_side_ff;
      rd_idx_in    = rd_idx_ff;
      low_hit_in   = low_hit_ff;
      top_hit_in   = top_hit_ff;
      top_pos0_in  = top_pos0_ff;
      top_pos1_in  = top_pos1_ff;
      res_in       = res_ff;
      mem_we       = 1'b0;
      alu_op       = '{sub: 1'b0, round: 1'b0};
      alu_a        = acc_ff;
      alu_b        = size_w;

      // compare the mark read issued in the previous cycle
      if (rd_pend_ff) begin
         if (rd_last) begin
            top_hit_in[rd_side_ff] = rd_hit;
            if (rd_side_ff) begin
               top_pos1_in = rd_pos;
            end else begin
               top_pos0_in = rd_pos;
            end
         end else if (rd_hit) begin
            low_hit_in[rd_side_ff] = 1'b1;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               cmd_in       = req_chan.data.cmd;
               side_in      = req_chan.data.side;
               size_in      = req_chan.data.size;
               al_in        = req_chan.data.align_log2;
               tag_in       = tag_ext[TAG_WIDTH-1:0];
               low_hit_in   = 2'b00;
               top_hit_in   = 2'b00;
               scan_side_in = 1'b0;
               scan_idx_in  = '0;
               unique case (req_chan.data.cmd)
                  CMD_ALLOC:         state_in = ST_AL_1;
                  CMD_BEGIN, CMD_END: state_in = ST_MARK;
                  CMD_FREE:          state_in = ST_SCAN;
                  default:           state_in = ST_IDLE;
               endcase
            end
         end
         ST_AL_1: begin
            if (side_ff) begin
               alu_op = '{sub: 1'b1, round: 1'b0};
               alu_a  = size_w;
               alu_b  = high_w;
            end else begin
               alu_op = '{sub: 1'b0, round: 1'b1};
               alu_a  = low_w;
               alu_b  = mask_w;
            end
            acc_in    = alu_result;
            borrow_in = alu_borrow;
            state_in  = ST_AL_2;
         end
         ST_AL_2: begin
            start_in = acc_ff;
            over_in  = ~borrow_ff & (|acc_ff);
            if (!side_ff) begin
               alu_op = '{sub: 1'b0, round: 1'b0};
               alu_a  = acc_ff;
               alu_b  = size_w;
            end else if (~borrow_ff & (|acc_ff)) begin
               alu_op = '{sub: 1'b0, round: 1'b1};
               alu_a  = acc_ff;
               alu_b  = mask_w;
            end else begin
               alu_op = '{sub: 1'b1, round: 1'b1};
               alu_a  = high_w;
               alu_b  = size_w;
            end
            acc_in    = alu_result;
            borrow_in = alu_borrow;
            state_in  = ST_AL_3;
         end
         ST_AL_3: begin
            hold_in = acc_ff;
            if (!side_ff) begin
               alu_op = '{sub: 1'b1, round: 1'b0};
               alu_a  = acc_ff;
               alu_b  = high_w;
            end else if (over_ff) begin
               alu_op = '{sub: 1'b0, round: 1'b0};
               alu_a  = low_w;
               alu_b  = acc_ff;
            end else begin
               alu_op = '{sub: 1'b1, round: 1'b0};
               alu_a  = low_w;
               alu_b  = acc_ff;
            end
            acc_in    = alu_result;
            borrow_in = alu_borrow;
            state_in  = ST_AL_DONE;
         end
         ST_AL_DONE: begin
            res_in = '{status: STATUS_OK, address: '0, shortfall: '0, freed_sides: 2'b00};
            if (side_ff && over_ff) begin
               res_in.status    = STATUS_NO_MEM;
               res_in.shortfall = sat_short;
            end else if (al_fail) begin
               res_in.status    = STATUS_NO_MEM;
               res_in.shortfall = sat_short;
            end else if (side_ff) begin
               res_in.address = hold_ff[31:0];
               high_top_in    = hold_ff[ADDR_WIDTH-1:0];
            end else begin
               res_in.address = start_ff[31:0];
               low_top_in     = hold_ff[ADDR_WIDTH-1:0];
            end
            state_in = ST_FINISH;
         end
         ST_MARK: begin
            res_in = '{status: STATUS_OK, address: '0, shortfall: '0, freed_sides: 2'b00};
            if (cmd_ff == CMD_BEGIN) begin
               if (open_ff[side_ff]) begin
                  res_in.status = STATUS_MARK_OPEN;
               end else if (side_cnt >= DEPTH_C) begin
                  res_in.status = STATUS_MARKS_FULL;
               end else begin
                  mem_we           = 1'b1;
                  open_in[side_ff] = 1'b1;
                  if (side_ff) begin
                     count1_in    = count1_ff + CW'(1);
                     open_tag1_in = tag_ff;
                  end else begin
                     count0_in    = count0_ff + CW'(1);
                     open_tag0_in = tag_ff;
                  end
               end
            end else begin
               if (!open_ff[side_ff] ||
                   ((side_ff ? open_tag1_ff : open_tag0_ff) != tag_ff)) begin
                  res_in.status = STATUS_END_MISMATCH;
               end else begin
                  open_in[side_ff] = 1'b0;
               end
            end
            state_in = ST_FINISH;
         end
         ST_SCAN: begin
            if (scan_idx_ff < scan_cnt) begin
               rd_pend_in  = 1'b1;
               rd_side_in  = scan_side_ff;
               rd_idx_in   = scan_idx_ff;
               scan_idx_in = scan_idx_ff + CW'(1);
            end else if (!scan_side_ff) begin
               scan_side_in = 1'b1;
               scan_idx_in  = '0;
            end else begin
               state_in = ST_SCAN_WAIT;
            end
         end
         ST_SCAN_WAIT: begin
            state_in = ST_FREE_DONE;
         end
         ST_FREE_DONE: begin
            res_in = '{status: STATUS_OK, address: '0, shortfall: '0, freed_sides: 2'b00};
            if (err_top[0]) begin
               res_in.status = STATUS_FREE_NOT_TOP;
            end else if (err_open[0]) begin
               res_in.status = STATUS_FREE_OPEN;
            end else if (err_top[1]) begin
               res_in.status = STATUS_FREE_NOT_TOP;
            end else if (err_open[1]) begin
               res_in.status = STATUS_FREE_OPEN;
            end else begin
               res_in.freed_sides = free_ok;
               if (free_ok[0]) begin
                  low_top_in = top_pos0_ff;
                  count0_in  = count0_ff - CW'(1);
               end
               if (free_ok[1]) begin
                  high_top_in = top_pos1_ff;
                  count1_in   = count1_ff - CW'(1);
               end
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // region size write re-initializes the allocator
      if (csr_wen) begin
         low_top_in   = '0;
         high_top_in  = csr_ext[ADDR_WIDTH-1:0];
         count0_in    = '0;
         count1_in    = '0;
         open_in      = 2'b00;
         open_tag0_in = '0;
         open_tag1_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         low_top_ff   <= '0;
         high_top_ff  <= rst_ext[ADDR_WIDTH-1:0];
         count0_ff    <= '0;
         count1_ff    <= '0;
         open_ff      <= 2'b00;
         open_tag0_ff <= '0;
         open_tag1_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         low_top_ff   <= low_top_in;
         high_top_ff  <= high_top_in;
         count0_ff    <= count0_in;
         count1_ff    <= count1_in;
         open_ff      <= open_in;
         open_tag0_ff <= open_tag0_in;
         open_tag1_ff <= open_tag1_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff   <= rd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      side_ff      <= side_in;
      size_ff      <= size_in;
      al_ff        <= al_in;
      tag_ff       <= tag_in;
      acc_ff       <= acc_in;
      borrow_ff    <= borrow_in;
      hold_ff      <= hold_in;
      start_ff     <= start_in;
      over_ff      <= over_in;
      scan_side_ff <= scan_side_in;
      scan_idx_ff  <= scan_idx_in;
      rd_side_ff   <= rd_side_in;
      rd_idx_ff    <= rd_idx_in;
      low_hit_ff   <= low_hit_in;
      top_hit_ff   <= top_hit_in;
      top_pos0_ff  <= top_pos0_in;
      top_pos1_ff  <= top_pos1_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

endmodule

FILE: rtl/core/tesa_checker.sv
// port-level checker for the two-ended stack allocator, with its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tesa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_address,
   input logic [32:0] rsp_shortfall,
   input logic [1:0]  rsp_freed
);
   import tesa_pkg::*;

   // a stalled response beat holds
   `TESA_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_address) && $stable(rsp_shortfall))

   // one item at a time
   `TESA_ASSERT(a_busy_after_accept, clock, reset, req_valid && req_ready |=> !req_ready)

   // failures grant nothing and free nothing
   `TESA_ASSERT(a_fail_clean, clock, reset, rsp_valid && rsp_status != STATUS_OK |-> rsp_address == 32'd0 && rsp_freed == 2'b00)

   // shortfall only on out of memory
   `TESA_ASSERT(a_short_only_oom, clock, reset, rsp_valid && rsp_status != STATUS_NO_MEM |-> rsp_shortfall == 33'd0)

   // after reset the block is idle with no response pending
   `TESA_ASSERT_NR(a_reset_idle, clock, reset |=> !rsp_valid)

endmodule

bind two_ended_stack_allocator tesa_checker u_tesa_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_status    (rsp_chan.data.status),
   .rsp_address   (rsp_chan.data.address),
   .rsp_shortfall (rsp_chan.data.shortfall),
   .rsp_freed     (rsp_chan.data.freed_sides)
);

FILE: tb/tesa_result_check.sv
// response predictor and comparator for the two-ended stack allocator
`timescale 1ns / 1ps

module tesa_result_check
   import tesa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic [31:0] csr_wdata,
   tesa_req_if         req_mon,
   tesa_rsp_if         rsp_mon,
   output int          mismatches,
   output int          outstanding,
   output int          checked
);

   localparam int          SLOTS     = 32;
   localparam logic [63:0] SHORT_CAP = 64'h1_FFFF_FFFF;

   logic [31:0]     region_size;
   logic [31:0]     low_top;
   logic [31:0]     high_top;
   logic [31:0]     mark_pos [2*SLOTS];
   logic [7:0]      mark_tag [2*SLOTS];
   bit              mark_live [2*SLOTS];
   int              mark_cnt [2];
   bit              open_flag [2];
   logic [7:0]      open_tag [2];
   rsp_payload_type awaited_rsp [$];
   rsp_payload_type want;

   function automatic void restart(logic [31:0] bytes);
      region_size = bytes;
      low_top = '0;
      high_top = bytes;
      for (int i = 0; i < 2*SLOTS; i++) begin
         mark_pos[i] = '0;
         mark_tag[i] = '0;
         mark_live[i] = 1'b0;
      end
      for (int s = 0; s < 2; s++) begin
         mark_cnt[s] = 0;
         open_flag[s] = 1'b0;
         open_tag[s] = '0;
      end
   endfunction

   function automatic logic [32:0] clip33(logic [63:0] v);
      return (v > SHORT_CAP) ? SHORT_CAP[32:0] : v[32:0];
   endfunction

   // searches one side for the tag; hit means the free may roll this side back
   function automatic logic [2:0] free_verdict(int s, logic [7:0] t, output bit hit);
      logic [2:0] verdict;
      bit         seen;
      verdict = STATUS_OK;
      seen = 1'b0;
      hit = 1'b0;
      for (int i = 0; i < mark_cnt[s] && i < SLOTS; i++) begin
         if (!seen && mark_live[s*SLOTS+i] && mark_tag[s*SLOTS+i] == t) begin
            seen = 1'b1;
            if (i != mark_cnt[s] - 1) verdict = STATUS_FREE_NOT_TOP;
            else if (open_flag[s]) verdict = STATUS_FREE_OPEN;
            else hit = 1'b1;
         end
      end
      return verdict;
   endfunction

   function automatic void roll_back(int s);
      int n;
      n = mark_cnt[s];
      if (n == 0 || n > SLOTS) return;
      mark_live[s*SLOTS+n-1] = 1'b0;
      do begin
         if (s == 0) low_top = mark_pos[s*SLOTS+n-1];
         else high_top = mark_pos[s*SLOTS+n-1];
         n--;
      end while (n > 0 && !mark_live[s*SLOTS+n-1]);
      mark_cnt[s] = n;
   endfunction

   function automatic rsp_payload_type allocator_step(req_payload_type r);
      rsp_payload_type o;
      logic [63:0]     mask;
      logic [63:0]     start;
      logic [63:0]     fin;
      logic [63:0]     gap;
      logic [63:0]     lo;
      logic [63:0]     hi;
      logic [2:0]      v_lo;
      logic [2:0]      v_hi;
      bit              hit_lo;
      bit              hit_hi;
      int              s;
      int              k;
      o = '0;
      s = r.side;
      mask = (64'd1 << r.align_log2) - 64'd1;
      lo = {32'd0, low_top};
      hi = {32'd0, high_top};
      case (r.cmd)
         CMD_ALLOC: begin
            if (s == 0) begin
               start = (lo + mask) & ~mask;
               fin = start + {32'd0, r.size};
               if (fin > hi) begin
                  o.status = STATUS_NO_MEM;
                  o.shortfall = clip33(fin - hi);
               end else begin
                  o.address = start[31:0];
                  low_top = fin[31:0];
               end
            end else if (r.size > high_top) begin
               gap = {32'd0, r.size} - hi;
               o.status = STATUS_NO_MEM;
               o.shortfall = clip33(lo + ((gap + mask) & ~mask));
            end else begin
               start = (hi - {32'd0, r.size}) & ~mask;
               if (start < lo) begin
                  o.status = STATUS_NO_MEM;
                  o.shortfall = clip33(lo - start);
               end else begin
                  o.address = start[31:0];
                  high_top = start[31:0];
               end
            end
         end
         CMD_BEGIN: begin
            if (open_flag[s]) begin
               o.status = STATUS_MARK_OPEN;
            end else if (mark_cnt[s] >= SLOTS) begin
               o.status = STATUS_MARKS_FULL;
            end else begin
               k = s*SLOTS + mark_cnt[s];
               mark_pos[k] = (s != 0) ? high_top : low_top;
               mark_tag[k] = r.tag;
               mark_live[k] = 1'b1;
               mark_cnt[s]++;
               open_flag[s] = 1'b1;
               open_tag[s] = r.tag;
            end
         end
         CMD_END: begin
            if (!open_flag[s] || open_tag[s] != r.tag) o.status = STATUS_END_MISMATCH;
            else open_flag[s] = 1'b0;
         end
         default: begin
            v_lo = free_verdict(0, r.tag, hit_lo);
            v_hi = free_verdict(1, r.tag, hit_hi);
            if (v_lo != STATUS_OK) begin
               o.status = v_lo;
            end else if (v_hi != STATUS_OK) begin
               o.status = v_hi;
            end else begin
               if (hit_lo) begin
                  roll_back(0);
                  o.freed_sides[0] = 1'b1;
               end
               if (hit_hi) begin
                  roll_back(1);
                  o.freed_sides[1] = 1'b1;
               end
            end
         end
      endcase
      return o;
   endfunction

   function automatic void compare_field(string field, logic [32:0] exp_v, logic [32:0] got_v);
      if (exp_v !== got_v) begin
         $error("%s expected %0h actual %0h", field, exp_v, got_v);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         restart(MEM_SIZE_RESET);
         awaited_rsp.delete();
      end else begin
         if (csr_wen) restart(csr_wdata);
         if (rsp_mon.valid && rsp_mon.ready) begin
            checked++;
            if (awaited_rsp.size() == 0) begin
               $error("response beat with no request waiting");
               mismatches++;
            end else begin
               want = awaited_rsp.pop_front();
               compare_field("status", 33'(want.status), 33'(rsp_mon.data.status));
               compare_field("address", 33'(want.address), 33'(rsp_mon.data.address));
               compare_field("shortfall", want.shortfall, rsp_mon.data.shortfall);
               compare_field("freed_sides", 33'(want.freed_sides),
                             33'(rsp_mon.data.freed_sides));
            end
         end
         if (req_mon.valid && req_mon.ready) awaited_rsp.push_back(allocator_step(req_mon.data));
      end
      outstanding <= awaited_rsp.size();
   end

endmodule

FILE: tb/testbench.sv
// stimulus, clock, reset and verdict for the two-ended stack allocator
`timescale 1ns / 1ps

module testbench;
   import tesa_pkg::*;

   localparam int LIMIT_CYCLES = 400000;
   localparam int STACK_SLOTS  = 32;
   localparam int DRAIN_CYCLES = 80;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wen;
   logic [31:0] csr_wdata;
   int          mismatches;
   int          outstanding;
   int          checked;
   int          sent_beats = 0;
   int          cycle_count = 0;
   int          region_count = 1;
   bit          quiet = 1'b0;

   // mark stacks as the stimulus expects them, used to aim frees and ends
   logic [7:0]  shadow_tag [2][STACK_SLOTS];
   int          shadow_depth [2];
   bit          shadow_open [2];
   logic [7:0]  shadow_open_tag [2];

   tesa_req_if req_chan ();
   tesa_rsp_if rsp_chan ();

   two_ended_stack_allocator uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata)
   );

   tesa_result_check result_check (
      .clock       (clock),
      .reset       (reset),
      .csr_wen     (csr_wen),
      .csr_wdata   (csr_wdata),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .checked     (checked)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= quiet || ($urandom_range(0, 99) >= 20);
      end
   end

   function automatic logic [31:0] pick_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return 32'd0;
      if (r < 55) return $urandom_range(1, 256);
      if (r < 80) return $urandom_range(1, 65536);
      if (r < 92) return $urandom;
      return $urandom | 32'h8000_0000;
   endfunction

   function automatic logic [4:0] pick_align();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 6);
      if (r < 90) return $urandom_range(0, 16);
      return $urandom_range(0, 31);
   endfunction

   function automatic void clear_shadow();
      for (int s = 0; s < 2; s++) begin
         shadow_depth[s] = 0;
         shadow_open[s] = 1'b0;
         shadow_open_tag[s] = '0;
      end
   endfunction

   task automatic send_beat(req_payload_type beat);
      if (!quiet && $urandom_range(0, 99) < 20) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data <= beat;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      sent_beats++;
   endtask

   task automatic issue(logic [1:0] cmd, logic side, logic [31:0] size, logic [4:0] align,
                        logic [7:0] tag);
      req_payload_type beat;
      bit              blocked;
      bit              found [2];
      bit              hit [2];
      beat.cmd = cmd;
      beat.side = side;
      beat.size = size;
      beat.align_log2 = align;
      beat.tag = tag;
      case (cmd)
         CMD_BEGIN: begin
            if (!shadow_open[side] && shadow_depth[side] < STACK_SLOTS) begin
               shadow_tag[side][shadow_depth[side]] = tag;
               shadow_depth[side]++;
               shadow_open[side] = 1'b1;
               shadow_open_tag[side] = tag;
            end
         end
         CMD_END: begin
            if (shadow_open[side] && shadow_open_tag[side] == tag) shadow_open[side] = 1'b0;
         end
         CMD_FREE: begin
            blocked = 1'b0;
            for (int s = 0; s < 2; s++) begin
               found[s] = 1'b0;
               hit[s] = 1'b0;
               for (int i = 0; i < shadow_depth[s]; i++) begin
                  if (!found[s] && shadow_tag[s][i] == tag) begin
                     found[s] = 1'b1;
                     if (i == shadow_depth[s] - 1 && !shadow_open[s]) hit[s] = 1'b1;
                     else blocked = 1'b1;
                  end
               end
            end
            for (int s = 0; s < 2; s++) begin
               if (!blocked && hit[s]) shadow_depth[s]--;
            end
         end
         default: ;
      endcase
      send_beat(beat);
   endtask

   task automatic mark_block(logic side);
      logic [7:0] tag;
      tag = $urandom_range(0, 255);
      issue(CMD_BEGIN, side, $urandom, $urandom_range(0, 31), tag);
      repeat ($urandom_range(0, 3)) issue(CMD_ALLOC, side, pick_size(), pick_align(), tag);
      issue(CMD_END, side, $urandom, $urandom_range(0, 31), tag);
   endtask

   task automatic random_action(int free_pct);
      int         r;
      logic       s;
      logic [7:0] tag;
      r = $urandom_range(0, 99);
      s = $urandom_range(0, 1);
      tag = $urandom_range(0, 255);
      if (r < 35) begin
         issue(CMD_ALLOC, s, pick_size(), pick_align(), tag);
      end else if (r < 55) begin
         mark_block(s);
      end else if (r < 55 + free_pct) begin
         if (shadow_depth[s] == 0) s = ~s;
         if (shadow_depth[s] > 0 && $urandom_range(0, 99) < 85)
            tag = shadow_tag[s][shadow_depth[s] - 1];
         issue(CMD_FREE, $urandom_range(0, 1), $urandom, $urandom_range(0, 31), tag);
      end else if (r < 65 + free_pct) begin
         if (shadow_open[s]) issue(CMD_END, s, $urandom, pick_align(), shadow_open_tag[s]);
         else issue(CMD_BEGIN, s, $urandom, pick_align(), tag);
      end else begin
         issue($urandom_range(0, 3), s, $urandom, $urandom_range(0, 31), tag);
      end
   endtask

   task automatic run_phase(int target, int free_pct);
      int stop;
      stop = sent_beats + target;
      while (sent_beats < stop) random_action(free_pct);
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic set_region(logic [31:0] bytes);
      settle();
      csr_wen <= 1'b1;
      csr_wdata <= bytes;
      @(posedge clock);
      csr_wen <= 1'b0;
      clear_shadow();
      region_count++;
      @(posedge clock);
   endtask

   // push both stacks past their depth, with random-size allocations in between
   task automatic fill_stacks();
      logic [7:0] tag;
      for (int s = 0; s < 2; s++) begin
         for (int i = 0; i < STACK_SLOTS + 1; i++) begin
            tag = $urandom_range(0, 255);
            issue(CMD_BEGIN, s, $urandom, pick_align(), tag);
            if ($urandom_range(0, 3) == 0) issue(CMD_ALLOC, s, pick_size(), pick_align(), tag);
            issue(CMD_END, s, $urandom, pick_align(), tag);
         end
      end
   endtask

   initial begin
      req_chan.valid <= 1'b0;
      req_chan.data <= '0;
      csr_wen <= 1'b0;
      csr_wdata <= '0;
      clear_shadow();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      issue(CMD_END, 1'b1, 32'd0, 5'd0, 8'h03);
      issue(CMD_ALLOC, 1'b0, 32'd1, 5'd0, 8'h00);
      issue(CMD_ALLOC, 1'b0, 32'd0, 5'd31, 8'h00);
      issue(CMD_ALLOC, 1'b1, 32'hFFFF_FFFF, 5'd31, 8'h00);
      issue(CMD_ALLOC, 1'b1, 32'd16, 5'd4, 8'h00);
      issue(CMD_ALLOC, 1'b0, 32'hFFFF_FFFF, 5'd0, 8'h00);
      issue(CMD_ALLOC, 1'b1, 32'd0, 5'd0, 8'h00);
      issue(CMD_BEGIN, 1'b0, 32'd0, 5'd0, 8'h00);
      issue(CMD_BEGIN, 1'b0, 32'd0, 5'd0, 8'h01);
      issue(CMD_END, 1'b0, 32'd0, 5'd0, 8'hFF);
      issue(CMD_ALLOC, 1'b0, 32'd100, 5'd3, 8'h00);
      issue(CMD_END, 1'b0, 32'd0, 5'd0, 8'h00);
      issue(CMD_FREE, 1'b0, 32'd0, 5'd0, 8'h00);
      issue(CMD_BEGIN, 1'b1, 32'd0, 5'd0, 8'hAA);
      issue(CMD_FREE, 1'b1, 32'd0, 5'd0, 8'hAA);
      issue(CMD_END, 1'b1, 32'd0, 5'd0, 8'hAA);
      issue(CMD_BEGIN, 1'b1, 32'd0, 5'd0, 8'h55);
      issue(CMD_END, 1'b1, 32'd0, 5'd0, 8'h55);
      issue(CMD_FREE, 1'b0, 32'd0, 5'd0, 8'hAA);
      issue(CMD_FREE, 1'b0, 32'd0, 5'd0, 8'h55);
      issue(CMD_FREE, 1'b1, 32'd0, 5'd0, 8'hAA);
      issue(CMD_FREE, 1'b0, 32'd0, 5'd0, 8'h77);
      issue(CMD_BEGIN, 1'b0, 32'd0, 5'd0, 8'hC3);
      issue(CMD_END, 1'b0, 32'd0, 5'd0, 8'hC3);
      issue(CMD_BEGIN, 1'b1, 32'd0, 5'd0, 8'hC3);
      issue(CMD_END, 1'b1, 32'd0, 5'd0, 8'hC3);
      issue(CMD_FREE, 1'b1, 32'd0, 5'd0, 8'hC3);

      run_phase(95, 20);
      settle();
      run_phase(95, 20);

      set_region(32'h0000_1000);
      run_phase(190, 20);

      set_region(32'h0000_0000);
      quiet = 1'b1;
      run_phase(190, 10);
      quiet = 1'b0;

      set_region(32'hFFFF_FFFF);
      fill_stacks();
      run_phase(60, 25);

      set_region(32'h0001_0000);
      run_phase(190, 20);

      set_region($urandom);
      run_phase(190, 15);

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d request beats over %0d region sizes, %0d responses compared",
               sent_beats, region_count, checked);
      $display("allocations from both ends, nested and full mark stacks, blocked and good frees");
      if (mismatches == 0 && outstanding == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/tesa_pkg.sv
rtl/core/tesa_if.sv
rtl/core/tesa_alu.sv
rtl/core/tesa_mark_mem.sv
rtl/core/two_ended_stack_allocator.sv
rtl/core/tesa_checker.sv
tb/tesa_result_check.sv
tb/testbench.sv
